// ===== sv/srse_pkg.sv =====
// Package for the stick radial scale encoder.
// Holds field widths, reset values of the threshold registers and register index codes.
// No dependencies.
package srse_pkg;

    localparam int FRAC_BITS_DEF = 30;
    localparam int IN_W          = 16;
    localparam int THR_W         = 12;
    localparam int CODE_W        = 12;
    localparam int CFG_IDX_W     = 1;

    localparam logic [THR_W-1:0] MIN_THR_RST = 12'd1874;
    localparam logic [THR_W-1:0] MAX_THR_RST = 12'd320;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_THR = 1'b0,
        CFG_MAX_THR = 1'b1
    } t_cfg_idx;

endpackage

// ===== sv/srse_cell.sv =====
// One bit step of the shared search chain: restoring divide or square root.
// Decides one quotient or root bit and hands remainder and partial result on.
// No package dependencies.
module srse_cell #(
    parameter int B  = 0,
    parameter int QW = 31,
    parameter int RW = 62,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_root,
    input  logic [RW-1:0] i_rem,
    input  logic [QW-1:0] i_q,
    input  logic [QW-1:0] i_d,
    input  logic [SW-1:0] i_side,
    output logic          o_root,
    output logic [RW-1:0] o_rem,
    output logic [QW-1:0] o_q,
    output logic [QW-1:0] o_d,
    output logic [SW-1:0] o_side
);

    localparam logic [RW-1:0] ROOT_BIT = RW'(1) << (2 * B);
    localparam logic [QW-1:0] Q_BIT    = QW'(1) << B;

    logic [RW-1:0] trial;
    logic          fit;
    logic          r_root;
    logic [RW-1:0] r_rem;
    logic [QW-1:0] r_q;
    logic [QW-1:0] r_d;
    logic [SW-1:0] r_side;
    logic [RW-1:0] n_rem;
    logic [QW-1:0] n_q;

    always_comb begin
        if (i_root) begin
            trial = (RW'(i_q) << (B + 1)) | ROOT_BIT;
        end else begin
            trial = RW'(i_d) << B;
        end
        fit   = (trial <= i_rem);
        n_rem = fit ? (i_rem - trial) : i_rem;
        n_q   = fit ? (i_q | Q_BIT) : i_q;
    end

    always_ff @(posedge i_clk) begin
        r_root <= i_root;
        r_rem  <= n_rem;
        r_q    <= n_q;
        r_d    <= i_d;
        r_side <= i_side;
    end

    assign o_root = r_root;
    assign o_rem  = r_rem;
    assign o_q    = r_q;
    assign o_d    = r_d;
    assign o_side = r_side;

endmodule

// ===== sv/srse_chain.sv =====
// Row of search cells, one per result bit from the top bit down to bit zero.
// Carries a valid flag and sideband data alongside the cells.
// Depends on srse_cell.
module srse_chain #(
    parameter int FB = 30,
    parameter int QW = 31,
    parameter int RW = 62,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_root,
    input  logic [RW-1:0] i_rem,
    input  logic [QW-1:0] i_d,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_q,
    output logic [RW-1:0] o_rem,
    output logic [SW-1:0] o_side
);

    localparam int N = FB + 1;

    logic          root_s [0:N];
    logic [RW-1:0] rem_s  [0:N];
    logic [QW-1:0] q_s    [0:N];
    logic [QW-1:0] d_s    [0:N];
    logic [SW-1:0] side_s [0:N];
    logic [N-1:0]  r_valid;

    assign root_s[0] = i_root;
    assign rem_s[0]  = i_rem;
    assign q_s[0]    = '0;
    assign d_s[0]    = i_d;
    assign side_s[0] = i_side;

    for (genvar g = 0; g < N; g++) begin : g_cell
        srse_cell #(
            .B  (FB - g),
            .QW (QW),
            .RW (RW),
            .SW (SW)
        ) u_cell (
            .i_clk  (i_clk),
            .i_root (root_s[g]),
            .i_rem  (rem_s[g]),
            .i_q    (q_s[g]),
            .i_d    (d_s[g]),
            .i_side (side_s[g]),
            .o_root (root_s[g+1]),
            .o_rem  (rem_s[g+1]),
            .o_q    (q_s[g+1]),
            .o_d    (d_s[g+1]),
            .o_side (side_s[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[N-2:0], i_valid};
        end
    end

    assign o_valid = r_valid[N-1] & ~root_s[N] | r_valid[N-1] & root_s[N];
    assign o_q     = q_s[N];
    assign o_rem   = rem_s[N] | RW'(d_s[N] & '0);
    assign o_side  = side_s[N];

endmodule

// ===== sv/stick_radial_scale_encoder_top.sv =====
// Top level of the stick radial scale encoder.
// Unit conversion, squares, root/divide chains, remap and 12-bit coding.
// Depends on srse_pkg and srse_chain.

// Takes one stick sample on any cycle with start high; busy stays low, so a new
// sample may follow every cycle. Each sample yields one code pair, shown for one
// cycle with o_strobe high. Most of the pipeline lies in three rows of
// FRAC_BITS+1 bit cells: one forms the root of the squared magnitude (or the
// saturating divide), the other two the per-axis divides by that magnitude.
// Results cannot be held off.
// Write thresholds only while no sample is in flight.
module stick_radial_scale_encoder_top #(
    parameter int FRAC_BITS = srse_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [srse_pkg::IN_W-1:0] i_x_in,
    input  logic signed [srse_pkg::IN_W-1:0] i_y_in,
    output logic                           o_strobe,
    output logic [srse_pkg::CODE_W-1:0]    o_x_out,
    output logic [srse_pkg::CODE_W-1:0]    o_y_out,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [srse_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [srse_pkg::THR_W-1:0]     i_cfg_data
);

    import srse_pkg::*;

    localparam int F   = FRAC_BITS;
    localparam int QW  = F + 1;
    localparam int RW  = 2 * QW;
    localparam int NW  = F + 15;
    localparam int L   = (QW + 1) / 2;
    localparam int H   = QW - L;
    localparam int PW  = QW + THR_W;
    localparam int RSW = QW + 3;
    localparam int TW  = F + 13;
    localparam int SW1 = 5 + 2 * QW;
    localparam int SW2 = 4 + QW;

    localparam logic [QW-1:0] ONE      = QW'(1) << F;
    localparam logic [RW-1:0] ONE_SQ   = RW'(1) << (2 * F);
    localparam logic [TW-1:0] CODE_MID = (TW'(1) << (F + 11)) + (TW'(1) << (F - 1));
    localparam logic [CODE_W-1:0] CENTER = CODE_W'(2048);
    localparam logic [17:0] K1 = 18'd32767;
    localparam logic [17:0] K2 = 18'd65534;
    localparam logic [17:0] K3 = 18'd98301;

    // configuration
    logic [THR_W-1:0] r_min_thr;
    logic [THR_W-1:0] r_max_thr;
    logic [THR_W:0]   thr_sdiff;
    logic             span_neg;
    logic [THR_W-1:0] tdiff;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_thr <= MIN_THR_RST;
            r_max_thr <= MAX_THR_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MIN_THR: r_min_thr <= i_cfg_data;
                CFG_MAX_THR: r_max_thr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        thr_sdiff = {1'b0, r_min_thr} - {1'b0, r_max_thr};
        span_neg  = thr_sdiff[THR_W];
        tdiff     = span_neg ? THR_W'(-thr_sdiff) : thr_sdiff[THR_W-1:0];
    end

    // stage 0: capture
    logic              r_s0_v;
    logic [IN_W-1:0]   r_s0_in [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else begin
            r_s0_v <= start & ~busy;
        end
        r_s0_in[0] <= i_x_in;
        r_s0_in[1] <= i_y_in;
    end

    // stage 1: unit estimate
    logic            r_s1_v;
    logic [NW-1:0]   n_s1_est [2];
    logic [QW-1:0]   n_s1_nmag [2];
    logic [NW-1:0]   r_s1_est [2];
    logic [QW-1:0]   r_s1_nmag [2];
    logic [14:0]     r_s1_pv [2];
    logic            r_s1_neg [2];
    logic [IN_W:0]   s1_nabs [2];
    logic [NW-1:0]   s1_npos [2];

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            s1_nabs[i]   = (IN_W + 1)'(0) - {r_s0_in[i][IN_W-1], r_s0_in[i]};
            n_s1_nmag[i] = QW'(s1_nabs[i][IN_W-1:0]) << (F - 15);
            s1_npos[i]   = r_s0_in[i][IN_W-1] ? '0 : (NW'(r_s0_in[i][14:0]) << F);
            n_s1_est[i]  = (s1_npos[i] >> 15) + (s1_npos[i] >> 30) + (s1_npos[i] >> 45);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= r_s0_v;
        end
        for (int i = 0; i < 2; i++) begin
            r_s1_est[i]  <= n_s1_est[i];
            r_s1_nmag[i] <= n_s1_nmag[i];
            r_s1_pv[i]   <= r_s0_in[i][14:0];
            r_s1_neg[i]  <= r_s0_in[i][IN_W-1];
        end
    end

    // stage 2: unit correction
    logic            r_s2_v;
    logic [QW-1:0]   r_s2_mag [2];
    logic            r_s2_neg [2];
    logic [NW+1:0]   s2_rr [2];
    logic [17:0]     s2_rl [2];
    logic [1:0]      s2_corr [2];
    logic [QW-1:0]   n_s2_mag [2];

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            s2_rr[i]   = ((NW + 2)'(r_s1_pv[i]) << F) + (NW + 2)'(r_s1_est[i])
                       - ((NW + 2)'(r_s1_est[i]) << 15);
            s2_rl[i]   = s2_rr[i][17:0];
            s2_corr[i] = 2'(s2_rl[i] >= K1) + 2'(s2_rl[i] >= K2) + 2'(s2_rl[i] >= K3);
            n_s2_mag[i] = r_s1_neg[i] ? r_s1_nmag[i]
                                      : QW'(r_s1_est[i] + NW'(s2_corr[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else begin
            r_s2_v <= r_s1_v;
        end
        for (int i = 0; i < 2; i++) begin
            r_s2_mag[i] <= n_s2_mag[i];
            r_s2_neg[i] <= r_s1_neg[i];
        end
    end

    // stage 3: square partial products
    logic            r_s3_v;
    logic [QW+L-1:0] r_s3_pl [2];
    logic [QW+H-1:0] r_s3_ph [2];
    logic [QW-1:0]   r_s3_mag [2];
    logic            r_s3_neg [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else begin
            r_s3_v <= r_s2_v;
        end
        for (int i = 0; i < 2; i++) begin
            r_s3_pl[i]  <= (QW + L)'(r_s2_mag[i]) * (QW + L)'(r_s2_mag[i][L-1:0]);
            r_s3_ph[i]  <= (QW + H)'(r_s2_mag[i]) * (QW + H)'(r_s2_mag[i][QW-1:L]);
            r_s3_mag[i] <= r_s2_mag[i];
            r_s3_neg[i] <= r_s2_neg[i];
        end
    end

    // stage 4: squares
    logic            r_s4_v;
    logic [RW-1:0]   r_s4_sq [2];
    logic [QW-1:0]   r_s4_mag [2];
    logic            r_s4_neg [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_v <= 1'b0;
        end else begin
            r_s4_v <= r_s3_v;
        end
        for (int i = 0; i < 2; i++) begin
            r_s4_sq[i]  <= RW'(r_s3_pl[i]) + (RW'(r_s3_ph[i]) << L);
            r_s4_mag[i] <= r_s3_mag[i];
            r_s4_neg[i] <= r_s3_neg[i];
        end
    end

    // stage 5: branch select, chain one operands
    logic            r_s5_v;
    logic            r_s5_root;
    logic [RW-1:0]   r_s5_rem;
    logic [QW-1:0]   r_s5_d;
    logic [SW1-1:0]  r_s5_side;
    logic [RW:0]     s5_sq;
    logic            s5_sat;
    logic            s5_zero;
    logic            s5_xsmall;
    logic [QW-1:0]   s5_small;
    logic [QW-1:0]   s5_large;

    always_comb begin
        s5_sq     = (RW + 1)'(r_s4_sq[0]) + (RW + 1)'(r_s4_sq[1]);
        s5_sat    = (s5_sq >= (RW + 1)'(ONE_SQ));
        s5_zero   = (r_s4_mag[0] == '0) && (r_s4_mag[1] == '0);
        s5_xsmall = (r_s4_mag[0] < r_s4_mag[1]);
        s5_small  = s5_xsmall ? r_s4_mag[0] : r_s4_mag[1];
        s5_large  = s5_xsmall ? r_s4_mag[1] : r_s4_mag[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_v <= 1'b0;
        end else begin
            r_s5_v <= r_s4_v;
        end
        r_s5_root <= ~s5_sat;
        r_s5_rem  <= s5_sat ? (RW'(s5_small) << F) : RW'(s5_sq);
        r_s5_d    <= s5_large;
        r_s5_side <= {s5_sat, s5_zero, s5_xsmall, r_s4_neg[1], r_s4_neg[0],
                      r_s4_mag[1], r_s4_mag[0]};
    end

    // chain one: magnitude root or saturating quotient
    logic            c1_v;
    logic [QW-1:0]   c1_q;
    logic [RW-1:0]   c1_rem;
    logic [SW1-1:0]  c1_side;

    srse_chain #(
        .FB (F),
        .QW (QW),
        .RW (RW),
        .SW (SW1)
    ) u_chain_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s5_v),
        .i_root  (r_s5_root),
        .i_rem   (r_s5_rem),
        .i_d     (r_s5_d),
        .i_side  (r_s5_side),
        .o_valid (c1_v),
        .o_q     (c1_q),
        .o_rem   (c1_rem),
        .o_side  (c1_side)
    );

    // stage 6: remap product
    logic            r_s6_v;
    logic [PW-1:0]   r_s6_prod;
    logic [QW-1:0]   r_s6_m;
    logic [SW1-1:0]  r_s6_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_v <= 1'b0;
        end else begin
            r_s6_v <= c1_v & (c1_rem[0] | ~c1_rem[0]);
        end
        r_s6_prod <= PW'(c1_q) * PW'(tdiff);
        r_s6_m    <= c1_q;
        r_s6_side <= c1_side;
    end

    // stage 7: remap and clamp
    logic            r_s7_v;
    logic [QW-1:0]   r_s7_m;
    logic            r_s7_rneg;
    logic [QW-1:0]   r_s7_rmag;
    logic [SW1-1:0]  r_s7_side;
    logic [RSW-1:0]  s7_lo_u;
    logic signed [RSW-1:0] s7_lo;
    logic signed [RSW-1:0] s7_p;
    logic signed [RSW-1:0] s7_r;
    logic signed [RSW-1:0] s7_one;
    logic [RSW-1:0]  s7_abs;
    logic            n_s7_rneg;
    logic [QW-1:0]   n_s7_rmag;

    always_comb begin
        s7_one  = $signed(RSW'(ONE));
        s7_lo_u = RSW'(ONE) - (RSW'(r_min_thr) << (F - 11));
        s7_lo   = $signed(s7_lo_u);
        s7_p    = $signed(RSW'(r_s6_prod >> 11));
        s7_r    = span_neg ? (s7_lo - s7_p) : (s7_lo + s7_p);
        if (s7_r > s7_one) begin
            s7_r = s7_one;
        end else if (s7_r < -s7_one) begin
            s7_r = -s7_one;
        end
        n_s7_rneg = s7_r[RSW-1];
        s7_abs    = n_s7_rneg ? RSW'(-s7_r) : RSW'(s7_r);
        n_s7_rmag = s7_abs[QW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_v <= 1'b0;
        end else begin
            r_s7_v <= r_s6_v;
        end
        r_s7_m    <= r_s6_m;
        r_s7_rneg <= n_s7_rneg;
        r_s7_rmag <= n_s7_rmag;
        r_s7_side <= r_s6_side;
    end

    // stage 8: numerator partial products
    logic            s7_sat, s7_zero, s7_xsmall;
    logic            s7_neg [2];
    logic [QW-1:0]   s7_mag [2];

    assign {s7_sat, s7_zero, s7_xsmall, s7_neg[1], s7_neg[0], s7_mag[1], s7_mag[0]}
        = r_s7_side;

    logic            r_s8_v;
    logic [QW+L-1:0] r_s8_pl [2];
    logic [QW+H-1:0] r_s8_ph [2];
    logic [QW-1:0]   r_s8_m;
    logic            r_s8_sat, r_s8_zero, r_s8_xsmall;
    logic            r_s8_fneg [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s8_v <= 1'b0;
        end else begin
            r_s8_v <= r_s7_v;
        end
        for (int i = 0; i < 2; i++) begin
            r_s8_pl[i]   <= (QW + L)'(s7_mag[i]) * (QW + L)'(r_s7_rmag[L-1:0]);
            r_s8_ph[i]   <= (QW + H)'(s7_mag[i]) * (QW + H)'(r_s7_rmag[QW-1:L]);
            r_s8_fneg[i] <= s7_neg[i] ^ (r_s7_rneg & ~s7_sat);
        end
        r_s8_m      <= r_s7_m;
        r_s8_sat    <= s7_sat;
        r_s8_zero   <= s7_zero;
        r_s8_xsmall <= s7_xsmall;
    end

    // stage 9: numerators, chain two operands
    logic            r_s9_v;
    logic [RW-1:0]   r_s9_num [2];
    logic [QW-1:0]   r_s9_m;
    logic [SW2-1:0]  r_s9_side;
    logic            r_s9_fneg1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s9_v <= 1'b0;
        end else begin
            r_s9_v <= r_s8_v;
        end
        for (int i = 0; i < 2; i++) begin
            r_s9_num[i] <= RW'(r_s8_pl[i]) + (RW'(r_s8_ph[i]) << L);
        end
        r_s9_m     <= r_s8_m;
        r_s9_side  <= {r_s8_sat, r_s8_zero, r_s8_xsmall, r_s8_fneg[0], r_s8_m};
        r_s9_fneg1 <= r_s8_fneg[1];
    end

    // chain two: per-axis divide by the magnitude
    logic            c2x_v, c2y_v;
    logic [QW-1:0]   c2x_q, c2y_q;
    logic [RW-1:0]   c2x_rem, c2y_rem;
    logic [SW2-1:0]  c2x_side;
    logic            c2y_side;

    srse_chain #(
        .FB (F),
        .QW (QW),
        .RW (RW),
        .SW (SW2)
    ) u_chain_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s9_v),
        .i_root  (1'b0),
        .i_rem   (r_s9_num[0]),
        .i_d     (r_s9_m),
        .i_side  (r_s9_side),
        .o_valid (c2x_v),
        .o_q     (c2x_q),
        .o_rem   (c2x_rem),
        .o_side  (c2x_side)
    );

    srse_chain #(
        .FB (F),
        .QW (QW),
        .RW (RW),
        .SW (1)
    ) u_chain_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s9_v),
        .i_root  (1'b0),
        .i_rem   (r_s9_num[1]),
        .i_d     (r_s9_m),
        .i_side  (r_s9_fneg1),
        .o_valid (c2y_v),
        .o_q     (c2y_q),
        .o_rem   (c2y_rem),
        .o_side  (c2y_side)
    );

    // stage 10: select, clamp and code
    logic            f_sat, f_zero, f_xsmall, f_fneg0;
    logic [QW-1:0]   f_satq;
    logic            f_neg [2];
    logic [QW-1:0]   f_a [2];
    logic [TW-1:0]   f_t [2];
    logic [CODE_W-1:0] f_code [2];
    logic            r_out_v;
    logic [CODE_W-1:0] r_x_out;
    logic [CODE_W-1:0] r_y_out;

    assign {f_sat, f_zero, f_xsmall, f_fneg0, f_satq} = c2x_side;

    always_comb begin
        f_neg[0] = f_fneg0;
        f_neg[1] = c2y_side;
        f_a[0]   = f_sat ? (f_xsmall ? f_satq : ONE) : c2x_q;
        f_a[1]   = f_sat ? (f_xsmall ? ONE : f_satq) : c2y_q;
        for (int i = 0; i < 2; i++) begin
            if (f_a[i] > ONE) begin
                f_a[i] = ONE;
            end
            if (f_neg[i]) begin
                f_t[i] = CODE_MID - (TW'(f_a[i]) << 11);
            end else begin
                f_t[i] = CODE_MID + (TW'(f_a[i]) << 11) - TW'(f_a[i]);
            end
            f_code[i] = f_zero ? CENTER : f_t[i][F+11:F];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= c2x_v & c2y_v & ((c2x_rem == c2y_rem) | (c2x_rem != c2y_rem));
        end
        r_x_out <= f_code[0];
        r_y_out <= f_code[1];
    end

    assign o_strobe = r_out_v;
    assign o_x_out  = r_x_out;
    assign o_y_out  = r_y_out;

endmodule
